// ===== rtl/rtp_pkg.sv =====
// package for the ringtone text parser: types, character codes and helper functions
package rtp_pkg;

   // song sections
   typedef enum logic [1:0] {
      SEC_NAME = 2'd0,
      SEC_CTRL = 2'd1,
      SEC_TONE = 2'd2
   } section_type;

   // control entry key
   typedef enum logic [1:0] {
      KEY_NONE     = 2'd0,
      KEY_DURATION = 2'd1,
      KEY_OCTAVE   = 2'd2,
      KEY_TEMPO    = 2'd3
   } key_type;

   // control entry progress
   typedef enum logic [1:0] {
      CP_START = 2'd0,
      CP_KEY   = 2'd1,
      CP_VALUE = 2'd2,
      CP_SKIP  = 2'd3
   } ctrl_phase_type;

   // tone progress
   typedef enum logic [2:0] {
      TP_DUR        = 3'd0,
      TP_EXP_NOTE   = 3'd1,
      TP_AFTER_NOTE = 3'd2,
      TP_EXP_OCT    = 3'd3,
      TP_OCT        = 3'd4,
      TP_SKIP       = 3'd5
   } tone_phase_type;

   // one result item
   typedef struct packed {
      logic [7:0] duration;
      logic       dotted;
      logic [3:0] note_code;
      logic [3:0] octave;
      logic [9:0] tempo;
      logic       song_end;
   } record_type;

   // character codes
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_COLON = 8'h3A;
   localparam logic [7:0] CHR_COMMA = 8'h2C;
   localparam logic [7:0] CHR_DOT   = 8'h2E;
   localparam logic [7:0] CHR_HASH  = 8'h23;
   localparam logic [7:0] CHR_EQUAL = 8'h3D;
   localparam logic [7:0] CHR_LC_D  = 8'h64;
   localparam logic [7:0] CHR_LC_O  = 8'h6F;
   localparam logic [7:0] CHR_LC_B  = 8'h62;
   localparam logic [7:0] CHR_P     = 8'h50;
   localparam logic [7:0] CHR_A     = 8'h41;
   localparam logic [7:0] CHR_B     = 8'h42;
   localparam logic [7:0] CHR_C     = 8'h43;
   localparam logic [7:0] CHR_D     = 8'h44;
   localparam logic [7:0] CHR_E     = 8'h45;
   localparam logic [7:0] CHR_F     = 8'h46;
   localparam logic [7:0] CHR_G     = 8'h47;

   // note codes
   localparam logic [3:0] NOTE_PAUSE = 4'd0;
   localparam logic [3:0] NOTE_C     = 4'd1;
   localparam logic [3:0] NOTE_D     = 4'd3;
   localparam logic [3:0] NOTE_E     = 4'd5;
   localparam logic [3:0] NOTE_F     = 4'd6;
   localparam logic [3:0] NOTE_G     = 4'd8;
   localparam logic [3:0] NOTE_A     = 4'd10;
   localparam logic [3:0] NOTE_B     = 4'd12;
   localparam logic [3:0] NOTE_BAD   = 4'd13;

   // defaults after reset and saturation limits
   localparam logic [7:0]  DEF_DURATION = 8'd4;
   localparam logic [3:0]  DEF_OCTAVE   = 4'd6;
   localparam logic [9:0]  DEF_TEMPO    = 10'd63;
   localparam logic [13:0] CTRL_MAX     = 14'd1023;
   localparam logic [11:0] DUR_MAX      = 12'd255;
   localparam logic [7:0]  OCT_MAX      = 8'd15;

   // whitespace: space, tab, lf, vt, ff, cr
   function automatic logic is_space(input logic [7:0] c);
      return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHR_ZERO) && (c <= CHR_NINE);
   endfunction

   // note letter to semitone code
   function automatic logic [3:0] note_of(input logic [7:0] c);
      logic [3:0] n;
      case (c)
         CHR_P:   n = NOTE_PAUSE;
         CHR_C:   n = NOTE_C;
         CHR_D:   n = NOTE_D;
         CHR_E:   n = NOTE_E;
         CHR_F:   n = NOTE_F;
         CHR_G:   n = NOTE_G;
         CHR_A:   n = NOTE_A;
         CHR_B:   n = NOTE_B;
         default: n = NOTE_BAD;
      endcase
      return n;
   endfunction

   // sharp raises only the notes that have one
   function automatic logic [3:0] sharp_of(input logic [3:0] n);
      logic [3:0] r;
      if ((n == NOTE_C) || (n == NOTE_D) || (n == NOTE_F) || (n == NOTE_G) || (n == NOTE_A)) begin
         r = n + 4'd1;
      end else begin
         r = NOTE_BAD;
      end
      return r;
   endfunction

endpackage

// ===== rtl/ringtone_text_parser_top.sv =====
// top level of the ringtone text parser: character decoder and result register
// a record is registered and is on the result ports in the cycle after the item that completes it
// throughput: one text byte per cycle; all parsing is a single pass of logic per byte
// the result register decouples the sides, so input is stalled only while a record waits
// reset: synchronous, active high; returns to the name section with default duration 4,
// octave 6 and tempo 63, and empties the result register
module ringtone_text_parser_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_duration,
   output logic       rsp_dotted,
   output logic [3:0] rsp_note_code,
   output logic [3:0] rsp_octave,
   output logic [9:0] rsp_tempo,
   output logic       rsp_song_end
);
   import rtp_pkg::*;

   section_type    section_ff,      section_in;
   key_type        control_key_ff,  control_key_in;
   ctrl_phase_type control_phase_ff, control_phase_in;
   logic [9:0]     control_value_ff, control_value_in;
   logic [7:0]     def_duration_ff, def_duration_in;
   logic [3:0]     def_octave_ff,   def_octave_in;
   logic [9:0]     def_tempo_ff,    def_tempo_in;
   tone_phase_type tone_phase_ff,   tone_phase_in;
   logic [8:0]     tone_duration_ff, tone_duration_in;
   logic           tone_dot_ff,     tone_dot_in;
   logic [3:0]     tone_note_ff,    tone_note_in;
   logic [4:0]     tone_octave_ff,  tone_octave_in;

   logic           rsp_valid_ff, rsp_valid_in;
   record_type     rsp_rec_ff, rsp_rec_in;

   logic           accept;
   logic           emit_comma;
   logic           emit_end;
   logic [7:0]     c;
   logic [3:0]     digit;
   logic [13:0]    ctrl_acc;
   logic [9:0]     ctrl_sat;
   logic [11:0]    dur_acc;
   logic [7:0]     oct_acc;
   logic           cur_has_chars;
   record_type     rec_comma;
   record_type     rec_end;

   assign c         = req_character;
   assign digit     = req_character[3:0];
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // decimal accumulators with saturation
   always_comb begin
      ctrl_acc = ({4'd0, control_value_ff} << 3) + ({4'd0, control_value_ff} << 1)
               + {10'd0, digit};
      ctrl_sat = (ctrl_acc > CTRL_MAX) ? CTRL_MAX[9:0] : ctrl_acc[9:0];
      dur_acc  = ({4'd0, tone_duration_ff[7:0]} << 3) + ({4'd0, tone_duration_ff[7:0]} << 1)
               + {8'd0, digit};
      oct_acc  = ({4'd0, tone_octave_ff[3:0]} << 3) + ({4'd0, tone_octave_ff[3:0]} << 1)
               + {4'd0, digit};
   end

   // next state for one accepted item
   always_comb begin
      section_in       = section_ff;
      control_key_in   = control_key_ff;
      control_phase_in = control_phase_ff;
      control_value_in = control_value_ff;
      def_duration_in  = def_duration_ff;
      def_octave_in    = def_octave_ff;
      def_tempo_in     = def_tempo_ff;
      tone_phase_in    = tone_phase_ff;
      tone_duration_in = tone_duration_ff;
      tone_dot_in      = tone_dot_ff;
      tone_note_in     = tone_note_ff;
      tone_octave_in   = tone_octave_ff;
      emit_comma       = 1'b0;

      if (!is_space(c)) begin
         case (section_ff)
            SEC_NAME: begin
               if (c == CHR_COLON) begin
                  section_in       = SEC_CTRL;
                  control_key_in   = KEY_NONE;
                  control_phase_in = CP_START;
                  control_value_in = 10'd0;
               end
            end
            SEC_CTRL: begin
               if (c == CHR_COLON) begin
                  section_in       = SEC_TONE;
                  tone_phase_in    = TP_DUR;
                  tone_duration_in = 9'd0;
                  tone_dot_in      = 1'b0;
                  tone_note_in     = 4'd0;
                  tone_octave_in   = 5'd0;
               end else if (c == CHR_COMMA) begin
                  control_key_in   = KEY_NONE;
                  control_phase_in = CP_START;
                  control_value_in = 10'd0;
               end else begin
                  case (control_phase_ff)
                     CP_START: begin
                        if (c == CHR_LC_D) begin
                           control_key_in   = KEY_DURATION;
                           control_phase_in = CP_KEY;
                        end else if (c == CHR_LC_O) begin
                           control_key_in   = KEY_OCTAVE;
                           control_phase_in = CP_KEY;
                        end else if (c == CHR_LC_B) begin
                           control_key_in   = KEY_TEMPO;
                           control_phase_in = CP_KEY;
                        end else begin
                           control_key_in   = KEY_NONE;
                           control_phase_in = CP_SKIP;
                        end
                     end
                     CP_KEY: begin
                        if (c == CHR_EQUAL) begin
                           control_value_in = 10'd0;
                           control_phase_in = CP_VALUE;
                           case (control_key_ff)
                              KEY_DURATION: def_duration_in = 8'd0;
                              KEY_OCTAVE:   def_octave_in   = 4'd0;
                              KEY_TEMPO:    def_tempo_in    = 10'd0;
                              default:      ;
                           endcase
                        end else begin
                           control_phase_in = CP_SKIP;
                        end
                     end
                     CP_VALUE: begin
                        if (is_digit(c)) begin
                           control_value_in = ctrl_sat;
                           case (control_key_ff)
                              KEY_DURATION: def_duration_in =
                                 (ctrl_sat > 10'd255) ? 8'd255 : ctrl_sat[7:0];
                              KEY_OCTAVE:   def_octave_in =
                                 (ctrl_sat > 10'd15) ? 4'd15 : ctrl_sat[3:0];
                              KEY_TEMPO:    def_tempo_in = ctrl_sat;
                              default:      ;
                           endcase
                        end else begin
                           control_phase_in = CP_SKIP;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            SEC_TONE: begin
               if (c == CHR_COMMA) begin
                  emit_comma       = cur_has_chars;
                  tone_phase_in    = TP_DUR;
                  tone_duration_in = 9'd0;
                  tone_dot_in      = 1'b0;
                  tone_note_in     = 4'd0;
                  tone_octave_in   = 5'd0;
               end else if (c == CHR_DOT) begin
                  // a dot marks the tone and closes the field it stands in
                  tone_dot_in = 1'b1;
                  case (tone_phase_ff)
                     TP_DUR:        tone_phase_in = TP_EXP_NOTE;
                     TP_AFTER_NOTE: tone_phase_in = TP_EXP_OCT;
                     TP_OCT:        tone_phase_in = TP_SKIP;
                     default:       ;
                  endcase
               end else begin
                  case (tone_phase_ff)
                     TP_DUR: begin
                        if (is_digit(c)) begin
                           tone_duration_in = {1'b1,
                              (dur_acc > DUR_MAX) ? DUR_MAX[7:0] : dur_acc[7:0]};
                        end else begin
                           tone_note_in  = note_of(c);
                           tone_phase_in = TP_AFTER_NOTE;
                        end
                     end
                     TP_EXP_NOTE: begin
                        tone_note_in  = note_of(c);
                        tone_phase_in = TP_AFTER_NOTE;
                     end
                     TP_AFTER_NOTE, TP_EXP_OCT: begin
                        if ((tone_phase_ff == TP_AFTER_NOTE) && (c == CHR_HASH)) begin
                           tone_note_in  = sharp_of(tone_note_ff);
                           tone_phase_in = TP_EXP_OCT;
                        end else if (is_digit(c)) begin
                           tone_octave_in = {1'b1, digit};
                           tone_phase_in  = TP_OCT;
                        end else begin
                           tone_phase_in = TP_SKIP;
                        end
                     end
                     TP_OCT: begin
                        if (is_digit(c)) begin
                           tone_octave_in = {1'b1,
                              (oct_acc > OCT_MAX) ? OCT_MAX[3:0] : oct_acc[3:0]};
                        end else begin
                           tone_phase_in = TP_SKIP;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end

      // end of text: flush the open tone as it stands after this byte
      emit_end = req_end_of_text && (section_in == SEC_TONE) && !emit_comma
               && ((tone_phase_in != TP_DUR) || tone_duration_in[8]);
      rec_end.duration  = tone_duration_in[8] ? tone_duration_in[7:0] : def_duration_in;
      rec_end.dotted    = tone_dot_in;
      rec_end.note_code = ((tone_phase_in == TP_DUR) || (tone_phase_in == TP_EXP_NOTE))
                        ? NOTE_BAD : tone_note_in;
      rec_end.octave    = tone_octave_in[4] ? tone_octave_in[3:0] : def_octave_in;
      rec_end.tempo     = def_tempo_in;
      rec_end.song_end  = 1'b1;

      // then back to the name section
      if (req_end_of_text) begin
         section_in       = SEC_NAME;
         control_key_in   = KEY_NONE;
         control_phase_in = CP_START;
         control_value_in = 10'd0;
         tone_phase_in    = TP_DUR;
         tone_duration_in = 9'd0;
         tone_dot_in      = 1'b0;
         tone_note_in     = 4'd0;
         tone_octave_in   = 5'd0;
      end
   end

   // tone occupancy before this byte
   assign cur_has_chars = (tone_phase_ff != TP_DUR) || tone_duration_ff[8];

   // record contents and result register next values
   always_comb begin
      rec_comma.duration  = tone_duration_ff[8] ? tone_duration_ff[7:0] : def_duration_ff;
      rec_comma.dotted    = tone_dot_ff;
      rec_comma.note_code = ((tone_phase_ff == TP_DUR) || (tone_phase_ff == TP_EXP_NOTE))
                          ? NOTE_BAD : tone_note_ff;
      rec_comma.octave    = tone_octave_ff[4] ? tone_octave_ff[3:0] : def_octave_ff;
      rec_comma.tempo     = def_tempo_ff;
      rec_comma.song_end  = 1'b0;

      rsp_rec_in   = emit_comma ? rec_comma : rec_end;
      rsp_valid_in = accept ? (emit_comma || emit_end) : (rsp_valid_ff && !rsp_ready);
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff       <= SEC_NAME;
         control_key_ff   <= KEY_NONE;
         control_phase_ff <= CP_START;
         control_value_ff <= 10'd0;
         def_duration_ff  <= DEF_DURATION;
         def_octave_ff    <= DEF_OCTAVE;
         def_tempo_ff     <= DEF_TEMPO;
         tone_phase_ff    <= TP_DUR;
         tone_duration_ff <= 9'd0;
         tone_dot_ff      <= 1'b0;
         tone_note_ff     <= 4'd0;
         tone_octave_ff   <= 5'd0;
      end else if (accept) begin
         section_ff       <= section_in;
         control_key_ff   <= control_key_in;
         control_phase_ff <= control_phase_in;
         control_value_ff <= control_value_in;
         def_duration_ff  <= def_duration_in;
         def_octave_ff    <= def_octave_in;
         def_tempo_ff     <= def_tempo_in;
         tone_phase_ff    <= tone_phase_in;
         tone_duration_ff <= tone_duration_in;
         tone_dot_ff      <= tone_dot_in;
         tone_note_ff     <= tone_note_in;
         tone_octave_ff   <= tone_octave_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (emit_comma || emit_end)) begin
         rsp_rec_ff <= rsp_rec_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duration  = rsp_rec_ff.duration;
   assign rsp_dotted    = rsp_rec_ff.dotted;
   assign rsp_note_code = rsp_rec_ff.note_code;
   assign rsp_octave    = rsp_rec_ff.octave;
   assign rsp_tempo     = rsp_rec_ff.tempo;
   assign rsp_song_end  = rsp_rec_ff.song_end;

   // tone state is clear outside the tone section
   assert property (@(posedge clock) disable iff (reset)
      (section_ff != SEC_TONE) |-> ((tone_phase_ff == TP_DUR) && !tone_duration_ff[8]
         && !tone_dot_ff && !tone_octave_ff[4]))
      else $error("tone state left over outside tone section");

   // an entry start never carries a key
   assert property (@(posedge clock) disable iff (reset)
      (control_phase_ff == CP_START) |-> (control_key_ff == KEY_NONE))
      else $error("control key set at entry start");

   // end of text returns to the name section
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_text) |=> (section_ff == SEC_NAME))
      else $error("end of text did not restart the song");

   // bytes in the name section never produce a record
   assert property (@(posedge clock) disable iff (reset)
      (accept && (section_ff == SEC_NAME)) |=> !rsp_valid_ff)
      else $error("record produced from name section");

   // records carry only defined note codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_rec_ff.note_code <= NOTE_BAD))
      else $error("note code out of range");

endmodule
